FILE: hw/rtl/cdds_pkg.sv
// Shared types, constants, date helpers and the microcode table of the date stepper.
`default_nettype none

package cdds_pkg;

  // Default field widths.
  localparam int YEAR_BITS_DEF   = 16;
  localparam int OFFSET_BITS_DEF = 16;

  localparam logic [3:0]    MONTH_JAN  = 4'd1;
  localparam logic [3:0]    MONTH_FEB  = 4'd2;
  localparam logic [3:0]    MONTH_APR  = 4'd4;
  localparam logic [3:0]    MONTH_JUN  = 4'd6;
  localparam logic [3:0]    MONTH_SEP  = 4'd9;
  localparam logic [3:0]    MONTH_NOV  = 4'd11;
  localparam logic [3:0]    MONTH_DEC  = 4'd12;

  localparam logic [4:0]    DAY_FIRST  = 5'd1;
  localparam logic [4:0]    LEN_LONG   = 5'd31;
  localparam logic [4:0]    LEN_SHORT  = 5'd30;
  localparam logic [4:0]    LEN_FEB_LP = 5'd29;
  localparam logic [4:0]    LEN_FEB    = 5'd28;

  // Datapath operations selected by the control word.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_CAPTURE,
    OP_LDCHK,
    OP_ADDINIT,
    OP_STEP,
    OP_EMIT
  } op_t;

  // Branch conditions.
  typedef enum logic [2:0] {
    CND_TRUE,
    CND_ADD,
    CND_OFF_ZERO,
    CND_STEP_END
  } cond_t;

  // Handshake a step waits on before it may leave.
  typedef enum logic [1:0] {
    WT_NONE,
    WT_IN,
    WT_OUT
  } wait_t;

  typedef logic [2:0] pc_t;

  localparam pc_t PC_DISPATCH = 3'd0;
  localparam pc_t PC_LDCHK    = 3'd1;
  localparam pc_t PC_ADDINIT  = 3'd2;
  localparam pc_t PC_STEP     = 3'd3;
  localparam pc_t PC_EMIT     = 3'd4;

  typedef struct packed {
    op_t   op;
    wait_t wt;
    cond_t cnd;
    pc_t   jmp_t;
    pc_t   jmp_f;
  } cw_t;

  // Status flags fed back from the datapath to the sequencer.
  typedef struct packed {
    logic in_fire;
    logic action_add;
    logic off_zero;
    logic step_end;
    logic out_free;
  } seq_stat_t;

  // The microprogram.
  function automatic cw_t ucode_rom(input pc_t pc);
    cw_t cw;
    cw = '{op: OP_NOP, wt: WT_NONE, cnd: CND_TRUE, jmp_t: PC_DISPATCH, jmp_f: PC_DISPATCH};
    case (pc)
      PC_DISPATCH: cw = '{op: OP_CAPTURE, wt: WT_IN,   cnd: CND_ADD,
                          jmp_t: PC_ADDINIT, jmp_f: PC_LDCHK};
      PC_LDCHK:    cw = '{op: OP_LDCHK,   wt: WT_NONE, cnd: CND_TRUE,
                          jmp_t: PC_EMIT,    jmp_f: PC_EMIT};
      PC_ADDINIT:  cw = '{op: OP_ADDINIT, wt: WT_NONE, cnd: CND_OFF_ZERO,
                          jmp_t: PC_EMIT,    jmp_f: PC_STEP};
      PC_STEP:     cw = '{op: OP_STEP,    wt: WT_NONE, cnd: CND_STEP_END,
                          jmp_t: PC_EMIT,    jmp_f: PC_STEP};
      PC_EMIT:     cw = '{op: OP_EMIT,    wt: WT_OUT,  cnd: CND_TRUE,
                          jmp_t: PC_DISPATCH, jmp_f: PC_DISPATCH};
      default:     cw = '{op: OP_NOP,     wt: WT_NONE, cnd: CND_TRUE,
                          jmp_t: PC_DISPATCH, jmp_f: PC_DISPATCH};
    endcase
    return cw;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m) inside
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = LEN_SHORT;
      MONTH_FEB: len = leap ? LEN_FEB_LP : LEN_FEB;
      default:   len = LEN_LONG;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/cdds_in_if.sv
// Input channel of the date stepper: valid/ready plus one request beat.
`default_nettype none

interface cdds_in_if import cdds_pkg::*; #(
  parameter int YEAR_BITS   = YEAR_BITS_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [4:0]                    load_day;
  logic [3:0]                    load_month;
  logic [YEAR_BITS-1:0]          load_year;
  logic signed [OFFSET_BITS-1:0] day_offset;

  modport source (
    output valid, action, load_day, load_month, load_year, day_offset,
    input  ready
  );

  modport sink (
    input  valid, action, load_day, load_month, load_year, day_offset,
    output ready
  );
endinterface

`default_nettype wire

FILE: hw/rtl/cdds_out_if.sv
// Result channel of the date stepper: valid/ready plus one date beat.
`default_nettype none

interface cdds_out_if import cdds_pkg::*; #(
  parameter int YEAR_BITS = YEAR_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [4:0]           cur_day;
  logic [3:0]           cur_month;
  logic [YEAR_BITS-1:0] cur_year;
  logic                 load_rejected;
  logic                 range_error;

  modport source (
    output valid, cur_day, cur_month, cur_year, load_rejected, range_error,
    input  ready
  );

  modport sink (
    input  valid, cur_day, cur_month, cur_year, load_rejected, range_error,
    output ready
  );
endinterface

`default_nettype wire

FILE: hw/rtl/cdds_seq.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
`default_nettype none

module cdds_seq import cdds_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  seq_stat_t stat_i,
  output cw_t       cw_o
);

  pc_t  pc_r;
  pc_t  pc_nxt;
  logic go;
  logic taken;

  assign cw_o = ucode_rom(pc_r);

  always_comb begin
    case (cw_o.wt)
      WT_NONE: go = 1'b1;
      WT_IN:   go = stat_i.in_fire;
      WT_OUT:  go = stat_i.out_free;
      default: go = 1'b1;
    endcase
  end

  always_comb begin
    case (cw_o.cnd)
      CND_TRUE:     taken = 1'b1;
      CND_ADD:      taken = stat_i.action_add;
      CND_OFF_ZERO: taken = stat_i.off_zero;
      CND_STEP_END: taken = stat_i.step_end;
      default:      taken = 1'b1;
    endcase
  end

  always_comb begin
    if (!go) begin
      pc_nxt = pc_r;
    end else if (taken) begin
      pc_nxt = cw_o.jmp_t;
    end else begin
      pc_nxt = cw_o.jmp_f;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_DISPATCH;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/calendar_date_day_stepper_unit.sv
// Top level of the Gregorian date stepper: microcoded control plus the date datapath.
// A load beat goes through the check step, then the emit step, which registers the result;
// an add beat loads the day counter and steps one day per cycle until the count runs out
// or a year bound stops it, then emits; a zero offset goes from counter load to emit.
// One beat at a time: the next beat is taken only once the last result is registered.
// Reset (synchronous, rst_n low) sets the date to 1/1/0 and empties the output.
`default_nettype none

module calendar_date_day_stepper_unit import cdds_pkg::*; #(
  parameter int YEAR_BITS   = YEAR_BITS_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  cdds_in_if.sink    in_ch,
  cdds_out_if.source out_ch
);

  // A year is a multiple of 25 exactly when the year times the inverse of 25, taken modulo
  // 2^YEAR_BITS, is no more than (2^YEAR_BITS-1)/25. The inverse modulo 2^32 truncates to
  // the inverse modulo any smaller power of two.
  localparam logic [31:0]          INV25_FULL = 32'hC28F5C29;
  localparam logic [YEAR_BITS-1:0] INV25      = INV25_FULL[YEAR_BITS-1:0];
  localparam logic [YEAR_BITS-1:0] MUL25_MAX  =
    YEAR_BITS'(((64'd1 << YEAR_BITS) - 64'd1) / 64'd25);

  // Leap when divisible by 4 and either not a multiple of 25 (so not a century) or
  // divisible by 16 as well (so a multiple of 400).
  function automatic logic year_is_leap(input logic [YEAR_BITS-1:0] y);
    logic [YEAR_BITS-1:0] prod;
    logic                 mult25;
    prod   = y * INV25;
    mult25 = (prod <= MUL25_MAX);
    return (y[1:0] == 2'b00) && (!mult25 || (y[3:0] == 4'b0000));
  endfunction

  cw_t       cw;
  seq_stat_t stat;

  // Current date, the flags of the last beat and the day counter.
  logic [4:0]           day_r,  day_nxt;
  logic [3:0]           month_r, month_nxt;
  logic [YEAR_BITS-1:0] year_r, year_nxt;
  logic                 rej_r, rej_nxt;
  logic                 rng_r, rng_nxt;
  logic [OFFSET_BITS-1:0] cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // Captured request beat.
  logic [4:0]             ld_day_r;
  logic [3:0]             ld_month_r;
  logic [YEAR_BITS-1:0]   ld_year_r;
  logic [OFFSET_BITS-1:0] off_r;
  logic                   dir_back_r;

  logic                 in_fire;
  logic                 emit_fire;

  logic                 off_neg;
  logic [OFFSET_BITS-1:0] off_mag;

  logic [4:0]           ld_mlen;
  logic                 ld_ok;

  logic                 cur_leap;
  logic [4:0]           cur_mlen;
  logic [3:0]           prev_month;
  logic [4:0]           prev_mlen;
  logic [4:0]           st_day;
  logic [3:0]           st_month;
  logic [YEAR_BITS-1:0] st_year;
  logic                 st_blocked;

  cdds_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .stat_i (stat),
    .cw_o   (cw)
  );

  // A beat is taken only while the program sits at dispatch and reset is released.
  assign in_ch.ready = (cw.wt == WT_IN) && rst_n;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // The result register is free when empty or being drained in this cycle.
  assign stat.out_free   = !out_valid_r || out_ch.ready;
  assign emit_fire       = (cw.op == OP_EMIT) && stat.out_free;

  assign stat.in_fire    = in_fire;
  assign stat.action_add = in_ch.action;
  assign stat.off_zero   = (off_r == '0);
  assign stat.step_end   = st_blocked || (cnt_r == OFFSET_BITS'(1));

  // Magnitude of the signed offset; the most negative value maps to its unsigned magnitude.
  assign off_neg = off_r[OFFSET_BITS-1];
  assign off_mag = off_neg ? (~off_r + OFFSET_BITS'(1)) : off_r;

  // Validity of the captured load.
  always_comb begin
    ld_mlen = month_len(ld_month_r, year_is_leap(ld_year_r));
    ld_ok   = (ld_month_r >= MONTH_JAN) && (ld_month_r <= MONTH_DEC) &&
              (ld_year_r != '0) && (ld_day_r >= DAY_FIRST) && (ld_day_r <= ld_mlen);
  end

  // One day forwards or backwards from the held date.
  always_comb begin
    cur_leap   = year_is_leap(year_r);
    cur_mlen   = month_len(month_r, cur_leap);
    prev_month = month_r - 4'd1;
    prev_mlen  = month_len(prev_month, cur_leap);
    st_day     = day_r;
    st_month   = month_r;
    st_year    = year_r;
    st_blocked = 1'b0;
    if (!dir_back_r) begin
      if (day_r >= cur_mlen) begin
        if (month_r >= MONTH_DEC) begin
          if (year_r == '1) begin
            st_blocked = 1'b1;
          end else begin
            st_day   = DAY_FIRST;
            st_month = MONTH_JAN;
            st_year  = year_r + YEAR_BITS'(1);
          end
        end else begin
          st_day   = DAY_FIRST;
          st_month = month_r + 4'd1;
        end
      end else begin
        st_day = day_r + 5'd1;
      end
    end else begin
      if (day_r <= DAY_FIRST) begin
        if (month_r <= MONTH_JAN) begin
          if (year_r == '0) begin
            st_blocked = 1'b1;
          end else begin
            st_day   = LEN_LONG;
            st_month = MONTH_DEC;
            st_year  = year_r - YEAR_BITS'(1);
          end
        end else begin
          st_month = prev_month;
          st_day   = prev_mlen;
        end
      end else begin
        st_day = day_r - 5'd1;
      end
    end
  end

  // Datapath next-state, steered by the current control word.
  always_comb begin
    day_nxt       = day_r;
    month_nxt     = month_r;
    year_nxt      = year_r;
    rej_nxt       = rej_r;
    rng_nxt       = rng_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    case (cw.op)
      OP_LDCHK: begin
        rng_nxt = 1'b0;
        if (ld_ok) begin
          day_nxt   = ld_day_r;
          month_nxt = ld_month_r;
          year_nxt  = ld_year_r;
          rej_nxt   = 1'b0;
        end else begin
          day_nxt   = DAY_FIRST;
          month_nxt = MONTH_JAN;
          year_nxt  = '0;
          rej_nxt   = 1'b1;
        end
      end
      OP_ADDINIT: begin
        cnt_nxt = off_mag;
        rej_nxt = 1'b0;
        rng_nxt = 1'b0;
      end
      OP_STEP: begin
        if (st_blocked) begin
          rng_nxt = 1'b1;
        end else begin
          day_nxt   = st_day;
          month_nxt = st_month;
          year_nxt  = st_year;
          cnt_nxt   = cnt_r - OFFSET_BITS'(1);
        end
      end
      OP_EMIT: begin
        if (emit_fire) begin
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      day_r       <= DAY_FIRST;
      month_r     <= MONTH_JAN;
      year_r      <= '0;
      rej_r       <= 1'b0;
      rng_r       <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      day_r       <= day_nxt;
      month_r     <= month_nxt;
      year_r      <= year_nxt;
      rej_r       <= rej_nxt;
      rng_r       <= rng_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: the captured beat and the result beat.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ld_day_r   <= in_ch.load_day;
      ld_month_r <= in_ch.load_month;
      ld_year_r  <= in_ch.load_year;
      off_r      <= in_ch.day_offset;
    end
    if (cw.op == OP_ADDINIT) begin
      dir_back_r <= off_neg;
    end
    if (emit_fire) begin
      out_ch.cur_day       <= day_r;
      out_ch.cur_month     <= month_r;
      out_ch.cur_year      <= year_r;
      out_ch.load_rejected <= rej_r;
      out_ch.range_error   <= rng_r;
    end
  end

  assign out_ch.valid = out_valid_r;

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench for the Gregorian date stepper: directed table, then random beats.
`default_nettype none

module testbench;
  import cdds_pkg::*;

  localparam int YEAR_BITS      = YEAR_BITS_DEF;
  localparam int OFFSET_BITS    = OFFSET_BITS_DEF;
  localparam int RANDOM_ITEMS   = 75;
  localparam int WATCHDOG_LIMIT = 140000;
  localparam int DRAIN_CYCLES   = 16;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_ADD  = 1'b1;

  localparam logic [YEAR_BITS-1:0] YEAR_TOP = '1;

  // Patterns the result receiver cycles through when deciding to stall.
  typedef enum int {RX_OPEN, RX_COIN, RX_QUARTER, RX_SPARSE} rx_pattern_t;

  typedef struct {
    logic                          action;
    logic [4:0]                    day;
    logic [3:0]                    month;
    logic [YEAR_BITS-1:0]          year;
    logic signed [OFFSET_BITS-1:0] offset;
  } date_req_t;

  typedef struct {
    logic [4:0]           day;
    logic [3:0]           month;
    logic [YEAR_BITS-1:0] year;
    logic                 rejected;
    logic                 range_err;
  } date_beat_t;

  // One stimulus row; want is only used when typed is set.
  typedef struct {
    date_req_t  req;
    bit         typed;
    date_beat_t want;
  } table_row_t;

  logic clk;
  logic rst_n;

  cdds_in_if  #(.YEAR_BITS(YEAR_BITS), .OFFSET_BITS(OFFSET_BITS)) in_ch ();
  cdds_out_if #(.YEAR_BITS(YEAR_BITS)) out_ch ();

  calendar_date_day_stepper_unit #(
    .YEAR_BITS  (YEAR_BITS),
    .OFFSET_BITS(OFFSET_BITS)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Our own copy of the date the block should be holding.
  logic [4:0]           cal_day;
  logic [3:0]           cal_month;
  logic [YEAR_BITS-1:0] cal_year;

  date_beat_t  pending_dates[$];
  table_row_t  directed_rows[$];
  int          mismatches;
  int          idle_cycles;
  int          burst_left;
  rx_pattern_t stall_mode;
  int          stall_left;
  int          stall_tick;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------- calendar predictor

  function automatic bit leap_year(input logic [YEAR_BITS-1:0] y);
    int unsigned v;
    v = y;
    return ((v % 4) == 0 && (v % 100) != 0) || ((v % 400) == 0);
  endfunction

  function automatic logic [4:0] days_in(input logic [3:0] m, input logic [YEAR_BITS-1:0] y);
    logic [4:0] n;
    case (m)
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: n = 5'd30;
      MONTH_FEB: n = leap_year(y) ? 5'd29 : 5'd28;
      default:   n = 5'd31;
    endcase
    return n;
  endfunction

  // One day on; refused at 31/12 of the top year.
  function automatic bit advance_one_day();
    if (cal_day < days_in(cal_month, cal_year)) begin
      cal_day = cal_day + 5'd1;
    end else if (cal_month < MONTH_DEC) begin
      cal_day   = DAY_FIRST;
      cal_month = cal_month + 4'd1;
    end else if (cal_year == YEAR_TOP) begin
      return 1'b0;
    end else begin
      cal_day   = DAY_FIRST;
      cal_month = MONTH_JAN;
      cal_year  = cal_year + 1'b1;
    end
    return 1'b1;
  endfunction

  // One day back; refused at 1/1/0.
  function automatic bit retreat_one_day();
    if (cal_day > DAY_FIRST) begin
      cal_day = cal_day - 5'd1;
    end else if (cal_month > MONTH_JAN) begin
      cal_month = cal_month - 4'd1;
      cal_day   = days_in(cal_month, cal_year);
    end else if (cal_year == '0) begin
      return 1'b0;
    end else begin
      cal_year  = cal_year - 1'b1;
      cal_month = MONTH_DEC;
      cal_day   = 5'd31;
    end
    return 1'b1;
  endfunction

  function automatic date_beat_t step_calendar(input date_req_t req);
    date_beat_t res;
    bit         back;
    int         span;
    int         n;
    res.rejected  = 1'b0;
    res.range_err = 1'b0;
    if (req.action == ACT_LOAD) begin
      if (req.month >= MONTH_JAN && req.month <= MONTH_DEC && req.year != '0 &&
          req.day != 5'd0 && req.day <= days_in(req.month, req.year)) begin
        cal_day   = req.day;
        cal_month = req.month;
        cal_year  = req.year;
      end else begin
        cal_day      = DAY_FIRST;
        cal_month    = MONTH_JAN;
        cal_year     = '0;
        res.rejected = 1'b1;
      end
    end else begin
      back = (req.offset < 0);
      span = back ? -int'(req.offset) : int'(req.offset);
      n    = 0;
      while (n < span && !res.range_err) begin
        if (!(back ? retreat_one_day() : advance_one_day()))
          res.range_err = 1'b1;
        n++;
      end
    end
    res.day   = cal_day;
    res.month = cal_month;
    res.year  = cal_year;
    return res;
  endfunction

  // ---------------------------------------------------------------- table helpers

  function automatic table_row_t ld_row(input int d, input int m, input int y);
    table_row_t r;
    r.req.action = ACT_LOAD;
    r.req.day    = d[4:0];
    r.req.month  = m[3:0];
    r.req.year   = y[YEAR_BITS-1:0];
    r.req.offset = '0;
    r.typed      = 1'b0;
    return r;
  endfunction

  function automatic table_row_t add_row(input int off);
    table_row_t r;
    r.req.action = ACT_ADD;
    r.req.day    = '0;
    r.req.month  = '0;
    r.req.year   = '0;
    r.req.offset = off[OFFSET_BITS-1:0];
    r.typed      = 1'b0;
    return r;
  endfunction

  function automatic table_row_t known(input table_row_t r, input int d, input int m,
                                       input int y, input bit rej, input bit rng);
    table_row_t k;
    k                = r;
    k.typed          = 1'b1;
    k.want.day       = d[4:0];
    k.want.month     = m[3:0];
    k.want.year      = y[YEAR_BITS-1:0];
    k.want.rejected  = rej;
    k.want.range_err = rng;
    return k;
  endfunction

  // ---------------------------------------------------------------- sender

  // Drives one request beat, idling first when the current burst is used up, and
  // records the expected date once the beat has been taken.
  task automatic send_beat(input table_row_t row);
    date_beat_t predicted;
    int         gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? 30 : $urandom_range(1, 10);
    end
    burst_left--;
    in_ch.valid      <= 1'b1;
    in_ch.action     <= row.req.action;
    in_ch.load_day   <= row.req.day;
    in_ch.load_month <= row.req.month;
    in_ch.load_year  <= row.req.year;
    in_ch.day_offset <= row.req.offset;
    do @(posedge clk); while (!in_ch.ready);
    predicted = step_calendar(row.req);
    pending_dates.push_back(row.typed ? row.want : predicted);
  endtask

  // ---------------------------------------------------------------- receiver stalls

  initial begin
    out_ch.ready <= 1'b0;
    stall_left = 0;
    stall_tick = 0;
    forever begin
      @(posedge clk);
      if (stall_left == 0) begin
        stall_mode = rx_pattern_t'($urandom_range(0, 3));
        stall_left = $urandom_range(16, 96);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        RX_OPEN:    out_ch.ready <= 1'b1;
        RX_COIN:    out_ch.ready <= 1'($urandom_range(0, 1));
        RX_QUARTER: out_ch.ready <= ((stall_tick % 4) == 3);
        default:    out_ch.ready <= ($urandom_range(0, 7) != 0);
      endcase
      stall_tick++;
    end
  end

  // ---------------------------------------------------------------- result check

  always @(posedge clk) begin
    date_beat_t want;
    if (out_ch.valid && out_ch.ready) begin
      if (pending_dates.size() == 0) begin
        $error("result beat with no date pending");
        mismatches++;
      end else begin
        want = pending_dates.pop_front();
        if (out_ch.cur_day !== want.day) begin
          $error("cur_day: expected %0d, got %0d", want.day, out_ch.cur_day);
          mismatches++;
        end
        if (out_ch.cur_month !== want.month) begin
          $error("cur_month: expected %0d, got %0d", want.month, out_ch.cur_month);
          mismatches++;
        end
        if (out_ch.cur_year !== want.year) begin
          $error("cur_year: expected %0d, got %0d", want.year, out_ch.cur_year);
          mismatches++;
        end
        if (out_ch.load_rejected !== want.rejected) begin
          $error("load_rejected: expected %0b, got %0b", want.rejected, out_ch.load_rejected);
          mismatches++;
        end
        if (out_ch.range_error !== want.range_err) begin
          $error("range_error: expected %0b, got %0b", want.range_err, out_ch.range_error);
          mismatches++;
        end
      end
    end
  end

  // A full-size add beat stalls both channels while it steps each day of its offset; the limit allows
  // several of those back to back before calling the run hung.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------- main sequence

  initial begin
    table_row_t row;
    int         k;
    int         pick;
    int         m;
    int         y;
    mismatches  = 0;
    idle_cycles = 0;
    burst_left  = 0;
    cal_day     = DAY_FIRST;
    cal_month   = MONTH_JAN;
    cal_year    = '0;

    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.action     <= ACT_LOAD;
    in_ch.load_day   <= '0;
    in_ch.load_month <= '0;
    in_ch.load_year  <= '0;
    in_ch.day_offset <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset state, both year bounds, the invalid-load cases and the leap rules.
    directed_rows = '{
      known(add_row(0),              1,  1,     0, 1'b0, 1'b0),
      known(add_row(-1),             1,  1,     0, 1'b0, 1'b1),
      known(add_row(-32768),         1,  1,     0, 1'b0, 1'b1),
      known(ld_row(31, 12, 65535),  31, 12, 65535, 1'b0, 1'b0),
      known(add_row(1),             31, 12, 65535, 1'b0, 1'b1),
      known(add_row(-1),            30, 12, 65535, 1'b0, 1'b0),
      known(add_row(32767),         31, 12, 65535, 1'b0, 1'b1),
      known(ld_row(0, 1, 2000),      1,  1,     0, 1'b1, 1'b0),
      known(ld_row(1, 0, 2000),      1,  1,     0, 1'b1, 1'b0),
      known(ld_row(1, 13, 2000),     1,  1,     0, 1'b1, 1'b0),
      known(ld_row(31, 15, 65535),   1,  1,     0, 1'b1, 1'b0),
      known(ld_row(1, 1, 0),         1,  1,     0, 1'b1, 1'b0),
      known(ld_row(31, 4, 2001),     1,  1,     0, 1'b1, 1'b0),
      known(ld_row(29, 2, 1900),     1,  1,     0, 1'b1, 1'b0),
      known(ld_row(29, 2, 2023),     1,  1,     0, 1'b1, 1'b0),
      known(ld_row(29, 2, 2024),    29,  2,  2024, 1'b0, 1'b0),
      known(ld_row(29, 2, 2000),    29,  2,  2000, 1'b0, 1'b0),
      known(add_row(1),              1,  3,  2000, 1'b0, 1'b0),
      known(add_row(-1),            29,  2,  2000, 1'b0, 1'b0),
      known(ld_row(1, 3, 2100),      1,  3,  2100, 1'b0, 1'b0),
      known(add_row(-1),            28,  2,  2100, 1'b0, 1'b0),
      known(ld_row(1, 1, 1),         1,  1,     1, 1'b0, 1'b0),
      known(add_row(-1),            31, 12,     0, 1'b0, 1'b0),
      add_row(32767),
      add_row(-32768)
    };
    foreach (directed_rows[i])
      send_beat(directed_rows[i]);

    for (k = 0; k < RANDOM_ITEMS; k++) begin
      // Halfway through, hold off until the block has answered everything.
      if (k == RANDOM_ITEMS / 2) begin
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_dates.size() != 0);
        burst_left = 0;
      end

      // Unused fields still carry random values so every bit toggles.
      row.typed      = 1'b0;
      row.req.day    = 5'($urandom_range(0, 31));
      row.req.month  = 4'($urandom_range(0, 15));
      row.req.year   = YEAR_BITS'($urandom_range(0, 65535));
      row.req.offset = OFFSET_BITS'($urandom_range(0, 65535));

      if ($urandom_range(0, 99) < 35) begin
        row.req.action = ACT_LOAD;
        pick = $urandom_range(0, 9);
        if (pick < 8) begin
          // Well-formed date, with years crowded near the bounds and the century rules.
          case ($urandom_range(0, 9))
            0, 1:    y = $urandom_range(1, 3);
            2, 3:    y = $urandom_range(65530, 65535);
            4:       y = $urandom_range(1, 655) * 100;
            default: y = $urandom_range(1, 65535);
          endcase
          m = $urandom_range(1, 12);
          row.req.month = m[3:0];
          row.req.year  = y[YEAR_BITS-1:0];
          row.req.day   = ($urandom_range(0, 2) == 0) ? days_in(row.req.month, row.req.year)
                                                      : 5'($urandom_range(1, 28));
        end else if (pick == 8) begin
          // Broken date: one field pushed out of its legal range.
          case ($urandom_range(0, 3))
            0:       row.req.day   = '0;
            1:       row.req.month = 4'($urandom_range(13, 15));
            2:       row.req.year  = '0;
            default: row.req.day   = 5'(days_in(row.req.month, row.req.year) + 1);
          endcase
        end
      end else begin
        row.req.action = ACT_ADD;
        pick = $urandom_range(0, 99);
        // Mostly short moves; a few full-range ones, since the block steps through every day of the offset.
        if (pick < 50)
          row.req.offset = OFFSET_BITS'(int'($urandom_range(0, 120)) - 60);
        else if (pick < 75)
          row.req.offset = OFFSET_BITS'(int'($urandom_range(0, 800)) - 400);
        else if (pick < 96)
          row.req.offset = OFFSET_BITS'(int'($urandom_range(0, 6000)) - 3000);
      end
      send_beat(row);
    end

    in_ch.valid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire
